// ===== rtl/pt64_pkg.sv =====
package pt64_pkg;

  localparam int unsigned W = 64;
  localparam int unsigned CntW = 7;

  typedef logic [W-1:0] word_t;

  // Main sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_BASE,
    S_TOMONT,
    S_EXP_MUL,
    S_EXP_SQR,
    S_EXP_NEXT,
    S_CHK,
    S_SQR,
    S_DONE
  } state_e;

  // Request to the bit-serial modular multiplier.
  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
  } mm_req_t;

  typedef struct packed {
    logic  done;
    word_t p;
  } mm_rsp_t;

  // Witness bases; index 0 to 2 are the small set, 3 to 9 the large set.
  localparam int unsigned NumBases = 10;

  function automatic word_t base_at(input logic [3:0] idx);
    word_t b;
    b = '0;
    case (idx)
      4'd0: b = word_t'(2);
      4'd1: b = word_t'(7);
      4'd2: b = word_t'(61);
      4'd3: b = word_t'(2);
      4'd4: b = word_t'(325);
      4'd5: b = word_t'(9375);
      4'd6: b = word_t'(28178);
      4'd7: b = word_t'(450775);
      4'd8: b = word_t'(9780504);
      4'd9: b = word_t'(1795265022);
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/pt64_modmul.sv =====
// Bit-serial modular product a*b mod n: one bit of a per cycle, MSB first,
// double-and-add with two conditional subtractions.
module pt64_modmul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pt64_pkg::word_t   n_i,
  input  pt64_pkg::mm_req_t req_i,
  output pt64_pkg::mm_rsp_t rsp_o
);

  logic                   busy_q, busy_d;
  logic [pt64_pkg::CntW-1:0] cnt_q, cnt_d;
  pt64_pkg::word_t        a_q, a_d, b_q, b_d, acc_q, acc_d;
  logic                   done_q, done_d;
  logic [pt64_pkg::W:0]   dbl, dbl_r, add, add_r;

  always_comb begin
    dbl   = {acc_q, 1'b0};
    dbl_r = (dbl >= {1'b0, n_i}) ? dbl - {1'b0, n_i} : dbl;
    add   = dbl_r + (a_q[pt64_pkg::W-1] ? {1'b0, b_q} : '0);
    add_r = (add >= {1'b0, n_i}) ? add - {1'b0, n_i} : add;
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      a_d    = req_i.a;
      b_d    = req_i.b;
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = add_r[pt64_pkg::W-1:0];
      a_d   = {a_q[pt64_pkg::W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == pt64_pkg::CntW'(pt64_pkg::W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.p    = acc_q;

endmodule

// ===== rtl/primality_test_64_top.sv =====
// Channel | Dir | tdata bits              | tuser/tlast
// s_axis  | in  | [63:0] number           | none
// m_axis  | out | [0] prime, [7:1] zero   | none
//
// An odd number above 1 runs a Miller-Rabin test, one witness after another, on one
// bit-serial modular multiplier. A witness squares once per bit of d, multiplies once
// more per set bit of d, and squares again for each further round of the check.
// Even values, 0 and 1 skip the test and go straight to the done state.
// Reset is asynchronous and active low and clears the sequencer. One request
// is in work at a time. A finished result moves into the output register and
// waits there until taken. s_axis_tready is high whenever the sequencer is
// idle, so the next request can start while the previous result waits.
// The residues are kept in plain form (a mod n).
module primality_test_64_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] number
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata     // [0] prime, [7:1] zero
);

  pt64_pkg::state_e  st_q, st_d;
  pt64_pkg::word_t   n_q, n_d, d_q, d_d, e_q, e_d, y_q, y_d, bs_q, bs_d, t_q, t_d;
  logic [3:0]        bi_q, bi_d;
  logic              ov_q, ov_d, ob_q, ob_d, vd_q, vd_d;
  pt64_pkg::mm_req_t req;
  pt64_pkg::mm_rsp_t rsp;
  pt64_pkg::word_t   ba, nm1;

  pt64_modmul u_mm (.clk_i(clk_i), .rst_ni(rst_ni), .n_i(n_q), .req_i(req), .rsp_o(rsp));

  assign ba  = pt64_pkg::base_at(bi_q);
  assign nm1 = n_q - 64'd1;

  // Next state.
  always_comb begin
    st_d = st_q;
    n_d = n_q; d_d = d_q; e_d = e_q; y_d = y_q; bs_d = bs_q; t_d = t_q;
    bi_d = bi_q; ov_d = ov_q; ob_d = ob_q; vd_d = vd_q;
    if (ov_q && m_axis_tready) ov_d = 1'b0;
    case (st_q)
      pt64_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          n_d = s_axis_tdata;
          d_d = s_axis_tdata - 64'd1;
          bi_d = (s_axis_tdata < (64'd1 << 31)) ? 4'd0 : 4'd3;
          if (s_axis_tdata == 64'd2) begin
            vd_d = 1'b1; st_d = pt64_pkg::S_DONE;
          end else if (s_axis_tdata < 64'd2 || !s_axis_tdata[0]) begin
            vd_d = 1'b0; st_d = pt64_pkg::S_DONE;
          end else begin
            st_d = pt64_pkg::S_TOMONT;
          end
        end
      end
      pt64_pkg::S_TOMONT: begin
        // Strip factors of two from d, one per cycle.
        if (!d_q[0]) d_d = {1'b0, d_q[63:1]};
        else st_d = pt64_pkg::S_BASE;
      end
      pt64_pkg::S_BASE: begin
        // The small set ends after its third witness, the large set after
        // the last entry of the table.
        if ((bi_q == 4'd3 && n_q < (64'd1 << 31)) || bi_q == 4'(pt64_pkg::NumBases) ||
            (n_q <= ba)) begin
          vd_d = 1'b1; st_d = pt64_pkg::S_DONE;
        end else begin
          bs_d = ba; y_d = 64'd1; e_d = d_q; t_d = d_q;
          st_d = pt64_pkg::S_EXP_NEXT;
        end
      end
      pt64_pkg::S_EXP_NEXT: begin
        if (e_q == '0) st_d = pt64_pkg::S_CHK;
        else if (e_q[0]) st_d = pt64_pkg::S_EXP_MUL;
        else st_d = pt64_pkg::S_EXP_SQR;
      end
      pt64_pkg::S_EXP_MUL: begin
        if (rsp.done) begin
          y_d = rsp.p; st_d = pt64_pkg::S_EXP_SQR;
        end
      end
      pt64_pkg::S_EXP_SQR: begin
        if (rsp.done) begin
          bs_d = rsp.p; e_d = {1'b0, e_q[63:1]}; st_d = pt64_pkg::S_EXP_NEXT;
        end
      end
      pt64_pkg::S_CHK: begin
        if (t_q != nm1 && y_q != 64'd1 && y_q != nm1) begin
          st_d = pt64_pkg::S_SQR;
        end else if (y_q != nm1 && !t_q[0]) begin
          vd_d = 1'b0; st_d = pt64_pkg::S_DONE;
        end else begin
          bi_d = bi_q + 4'd1;
          st_d = pt64_pkg::S_BASE;
        end
      end
      pt64_pkg::S_SQR: begin
        if (rsp.done) begin
          y_d = rsp.p; t_d = {t_q[62:0], 1'b0}; st_d = pt64_pkg::S_CHK;
        end
      end
      pt64_pkg::S_DONE: begin
        // The verdict moves out once the output register is free or is
        // being emptied in this cycle.
        if (!ov_q || m_axis_tready) begin
          ov_d = 1'b1; ob_d = vd_q; st_d = pt64_pkg::S_IDLE;
        end
      end
      default: st_d = pt64_pkg::S_IDLE;
    endcase
  end

  // Multiplier requests, issued on entry to each multiply state.
  always_comb begin
    req.start = 1'b0;
    req.a = y_q;
    req.b = bs_q;
    case (st_q)
      pt64_pkg::S_EXP_NEXT: begin
        req.start = (e_q != '0);
        req.a = e_q[0] ? y_q : bs_q;
        req.b = bs_q;
      end
      pt64_pkg::S_EXP_MUL: begin
        req.start = rsp.done;
        req.a = bs_q;
        req.b = bs_q;
      end
      pt64_pkg::S_CHK: begin
        req.start = (t_q != nm1 && y_q != 64'd1 && y_q != nm1);
        req.a = y_q;
        req.b = y_q;
      end
      default: req.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= pt64_pkg::S_IDLE;
      ov_q <= 1'b0;
      bi_q <= '0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
      bi_q <= bi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; d_q <= d_d; e_q <= e_d; y_q <= y_d;
    bs_q <= bs_d; t_q <= t_d; ob_q <= ob_d; vd_q <= vd_d;
  end

  assign s_axis_tready = (st_q == pt64_pkg::S_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {7'd0, ob_q};

endmodule
